[design/pidli_pkg.sv]
// ----------------------------------------------------------------------------
// pidli_pkg
// Shared types and constants for the leaky-integral PID unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pidli_pkg;

    localparam int ErrW    = 16;
    localparam int GainW   = 16;
    localparam int SumW    = 20;
    localparam int DerivW  = ErrW + 1;
    localparam int CfgIdxW = 2;
    localparam int CfgW    = 16;

    // Register indexes on the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_PROP  = 2'd0,
        CFG_GAIN_INTEG = 2'd1,
        CFG_GAIN_DERIV = 2'd2
    } pidli_cfg_index_t;

    typedef struct packed {
        logic signed [GainW-1:0] prop;
        logic signed [GainW-1:0] integ;
        logic signed [GainW-1:0] deriv;
    } pidli_gains_t;

    // One sample after the state update, on its way to the gain stage
    typedef struct packed {
        logic signed [ErrW-1:0]   err;
        logic signed [SumW-1:0]   integ;
        logic signed [DerivW-1:0] deriv;
    } pidli_item_t;

endpackage

`default_nettype wire

[design/pid_leaky_integral_unit.sv]
// ----------------------------------------------------------------------------
// pid_leaky_integral_unit
// PID controller with a leaky integrator and Q8.8 gains.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one signed 16-bit error sample per request. Each sample
//   yields exactly one m_* result: drive_value in m_tdata, clipped in
//   m_tuser. Gains are written on the cfg_* port (index 0 prop, 1 integ,
//   2 deriv); cfg_ready is always high, writes to index 3 are dropped.
//   Write gains only while no sample is in flight.
// Pipeline:
//   An accepted sample passes the state update stage, the gain product
//   stage and the result register. One sample per cycle while m_tready
//   is high; the integral recurrence closes within the state update stage.
// Reset:
//   aresetn (sync, active low) clears the gains, the integral, the last
//   error and all valid flags.
// Backpressure:
//   When m_tready is low, the result register holds and the two earlier
//   stages keep filling; s_tready drops only once all three are full.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_leaky_integral_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] err_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] drive_value
    output logic [0:0]       m_tuser,   // [0] clipped
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [pidli_pkg::CfgW-1:0] cfg_data
);

    localparam int SumW = pidli_pkg::SumW;
    localparam int ErrW = pidli_pkg::ErrW;
    // ceil(2^22 / 5): exact quotient for dividends below 2^22
    localparam logic [19:0] RecipFive = 20'd838861;

    pidli_pkg::pidli_gains_t gains_reg;
    logic signed [SumW-1:0]  leaky_sum_reg;
    logic signed [SumW-1:0]  leaky_sum_next;
    logic signed [ErrW-1:0]  prev_err_reg;
    logic                    item_valid_reg;
    pidli_pkg::pidli_item_t  item_reg;
    logic                    item_ready;
    logic                    accept;

    logic signed [ErrW-1:0]  err;
    logic                    sum_neg;
    logic signed [SumW:0]    sum_abs;
    logic [SumW:0]           mag4;
    logic [SumW+SumW:0]      prod;
    logic [SumW-2:0]         quot;
    logic signed [SumW:0]    decayed;
    logic signed [SumW:0]    sum_wide;

    assign cfg_ready = 1'b1;
    assign s_tready  = !item_valid_reg || item_ready;
    assign accept    = s_tvalid && s_tready;
    assign err       = $signed(s_tdata);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_reg <= '0;
        end else if (cfg_valid) begin
            case (pidli_pkg::pidli_cfg_index_t'(cfg_index))
                pidli_pkg::CFG_GAIN_PROP:  gains_reg.prop  <= $signed(cfg_data);
                pidli_pkg::CFG_GAIN_INTEG: gains_reg.integ <= $signed(cfg_data);
                pidli_pkg::CFG_GAIN_DERIV: gains_reg.deriv <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // sum*4/5 toward zero via reciprocal multiply on the magnitude; -2^19 decays to 0
    always_comb begin
        sum_neg        = leaky_sum_reg[SumW-1];
        sum_abs        = sum_neg ? -(SumW+1)'(leaky_sum_reg) : (SumW+1)'(leaky_sum_reg);
        mag4           = {sum_abs[SumW-2:0], 2'b00};
        prod           = mag4 * RecipFive;
        quot           = prod[SumW+SumW:22];
        decayed        = sum_neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
        sum_wide       = decayed + (SumW+1)'(err);
        leaky_sum_next = sum_wide[SumW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leaky_sum_reg  <= '0;
            prev_err_reg   <= '0;
            item_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                leaky_sum_reg <= leaky_sum_next;
                prev_err_reg  <= err;
            end
            if (s_tready) begin
                item_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.err   <= err;
            item_reg.integ <= leaky_sum_next;
            item_reg.deriv <= pidli_pkg::DerivW'(err) - pidli_pkg::DerivW'(prev_err_reg);
        end
    end

    pidli_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .gains      (gains_reg),
        .item_valid (item_valid_reg),
        .item_ready (item_ready),
        .item       (item_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

[design/pidli_mac.sv]
// ----------------------------------------------------------------------------
// pidli_mac
// Gain products, weighted sum, Q8.8 truncation and 16-bit saturation.
// Two registered stages: products, then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidli_mac (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pidli_pkg::pidli_gains_t gains,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire pidli_pkg::pidli_item_t  item,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [15:0]                m_tdata,   // [15:0] drive_value
    output logic [0:0]                 m_tuser    // [0] clipped
);

    localparam int PropW  = pidli_pkg::ErrW + pidli_pkg::GainW;
    localparam int IntegW = pidli_pkg::SumW + pidli_pkg::GainW;
    localparam int DervW  = pidli_pkg::DerivW + pidli_pkg::GainW;
    localparam int AccW   = IntegW + 2;
    localparam int QW     = AccW - 8;

    logic                     prod_valid_reg;
    logic signed [PropW-1:0]  prop_prod_reg;
    logic signed [IntegW-1:0] integ_prod_reg;
    logic signed [DervW-1:0]  deriv_prod_reg;

    logic                     out_valid_reg;
    logic [15:0]              drive_reg;
    logic                     clip_reg;
    logic [15:0]              drive_next;
    logic                     clip_next;

    logic                     out_ready;
    logic                     prod_ready;
    logic signed [AccW-1:0]   acc;
    logic signed [AccW-1:0]   acc_adj;
    logic signed [QW-1:0]     quot;

    assign out_ready  = !out_valid_reg || m_tready;
    assign prod_ready = !prod_valid_reg || out_ready;
    assign item_ready = prod_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && item_valid) begin
            prop_prod_reg  <= $signed(item.err)   * $signed(gains.prop);
            integ_prod_reg <= $signed(item.integ) * $signed(gains.integ);
            deriv_prod_reg <= $signed(item.deriv) * $signed(gains.deriv);
        end
    end

    // Divide by 256 toward zero: bias negative sums before the shift
    always_comb begin
        acc     = AccW'(prop_prod_reg) + AccW'(integ_prod_reg) + AccW'(deriv_prod_reg);
        acc_adj = acc + (acc[AccW-1] ? AccW'(255) : AccW'(0));
        quot    = acc_adj[AccW-1:8];
        if (quot > QW'(32767)) begin
            drive_next = 16'h7fff;
            clip_next  = 1'b1;
        end else if (quot < -QW'(32768)) begin
            drive_next = 16'h8000;
            clip_next  = 1'b1;
        end else begin
            drive_next = quot[15:0];
            clip_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && prod_valid_reg) begin
            drive_reg <= drive_next;
            clip_reg  <= clip_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = drive_reg;
    assign m_tuser[0] = clip_reg;

endmodule

`default_nettype wire

[design/pidli_checker.sv]
// ----------------------------------------------------------------------------
// pidli_checker
// Port-level checks for the leaky-integral PID unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pidli_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // clip flag only with a full-scale drive
    a_clip_full_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
        else $error("clip flag without saturated drive");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // with the result side free, input is never refused
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(m_tready) && m_tready && $past(aresetn) |-> s_tready)
        else $error("input stalled with free output");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind pid_leaky_integral_unit pidli_checker u_pidli_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
